[design/tca_pkg.sv]
`timescale 1ns / 1ps
package tca_pkg;

  localparam int QUEUE_DEPTH_DEF    = 16;
  localparam int SERVICE_BITS_DEF   = 8;
  localparam int REQUESTER_BITS_DEF = 16;

  localparam int ACTION_W = 2;
  localparam int STATUS_W = 3;
  localparam int LIMIT_W  = 8;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 8'd10;

  localparam logic [ACTION_W-1:0] ACT_ENQ_HIGH = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_ENQ_LOW  = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_SERVE    = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_ENQUEUED = 3'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL     = 3'd1;
  localparam logic [STATUS_W-1:0] STATUS_HIGH     = 3'd2;
  localparam logic [STATUS_W-1:0] STATUS_LOW      = 3'd3;
  localparam logic [STATUS_W-1:0] STATUS_NONE     = 3'd4;

  typedef enum logic {
    FSM_IDLE,
    FSM_READ
  } fsm_state_e;

endpackage

[design/tca_ram.sv]
`timescale 1ns / 1ps
module tca_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[design/two_class_queue_arbiter_top.sv]
`timescale 1ns / 1ps
// Two-class request arbiter: tags are queued in a high and a low FIFO, each held in its own
// single-port-read RAM, and a serve word grants from the high queue until the configured
// burst limit of consecutive high grants has gone out, then one low grant clears the run
// (with an empty low queue the high queue keeps being served). An enqueue or a serve that
// finds nothing is answered from the idle state; a serve that grants reads the selected
// queue's RAM, which returns the tag in the cycle after the read. One item is in flight
// at a time: the next word is taken only once the output register is empty or emptied at
// that edge, so a stalled result holds off the input. Queue RAMs need no reset clearing.
module two_class_queue_arbiter_top #(
  parameter int QUEUE_DEPTH    = tca_pkg::QUEUE_DEPTH_DEF,
  parameter int SERVICE_BITS   = tca_pkg::SERVICE_BITS_DEF,
  parameter int REQUESTER_BITS = tca_pkg::REQUESTER_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [tca_pkg::LIMIT_W-1:0]  cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [tca_pkg::ACTION_W-1:0] action_i,
  input  logic [SERVICE_BITS-1:0]      service_id_i,
  input  logic [REQUESTER_BITS-1:0]    requester_id_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [tca_pkg::STATUS_W-1:0] status_o,
  output logic [SERVICE_BITS-1:0]      granted_service_o,
  output logic [REQUESTER_BITS-1:0]    granted_requester_o
);

  import tca_pkg::*;

  localparam int PTR_W  = $clog2(QUEUE_DEPTH);
  localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
  localparam int TAG_W  = SERVICE_BITS + REQUESTER_BITS;
  localparam logic [PTR_W-1:0]  PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(QUEUE_DEPTH);

  fsm_state_e state_q, state_d;

  logic [PTR_W-1:0]   hi_rd_q, hi_rd_d, hi_wr_q, hi_wr_d;
  logic [PTR_W-1:0]   lo_rd_q, lo_rd_d, lo_wr_q, lo_wr_d;
  logic [FILL_W-1:0]  hi_fill_q, hi_fill_d, lo_fill_q, lo_fill_d;
  logic [LIMIT_W-1:0] burst_q, burst_d;
  logic [LIMIT_W-1:0] limit_q, limit_d;
  logic               sel_high_q, sel_high_d;

  logic                      out_valid_q, out_valid_d;
  logic [STATUS_W-1:0]       status_q, status_d;
  logic [SERVICE_BITS-1:0]   svc_q, svc_d;
  logic [REQUESTER_BITS-1:0] req_q, req_d;

  logic             hi_we, lo_we, hi_re, lo_re;
  logic [TAG_W-1:0] wtag, hi_rdata, lo_rdata, rtag;
  logic             slot_free, in_fire, at_limit;

  assign slot_free  = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == FSM_IDLE) && slot_free;
  assign in_fire    = in_valid_i && in_ready_o;
  assign at_limit   = burst_q >= limit_q;
  assign wtag       = {service_id_i, requester_id_i};
  assign rtag       = sel_high_q ? hi_rdata : lo_rdata;

  function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
    return (p == PTR_LAST) ? '0 : p + PTR_W'(1);
  endfunction

  always_comb begin
    state_d     = state_q;
    hi_rd_d     = hi_rd_q;
    hi_wr_d     = hi_wr_q;
    lo_rd_d     = lo_rd_q;
    lo_wr_d     = lo_wr_q;
    hi_fill_d   = hi_fill_q;
    lo_fill_d   = lo_fill_q;
    burst_d     = burst_q;
    limit_d     = cfg_we_i ? cfg_wdata_i : limit_q;
    sel_high_d  = sel_high_q;
    out_valid_d = out_valid_q && !out_ready_i;
    status_d    = status_q;
    svc_d       = svc_q;
    req_d       = req_q;
    hi_we       = 1'b0;
    lo_we       = 1'b0;
    hi_re       = 1'b0;
    lo_re       = 1'b0;

    case (state_q)
      FSM_IDLE: begin
        if (in_fire) begin
          // default word: nothing granted, answer right away
          out_valid_d = 1'b1;
          status_d    = STATUS_NONE;
          svc_d       = '0;
          req_d       = '0;
          case (action_i)
            ACT_ENQ_HIGH: begin
              if (hi_fill_q == FILL_MAX) begin
                status_d = STATUS_FULL;
              end else begin
                hi_we     = 1'b1;
                hi_wr_d   = next_ptr(hi_wr_q);
                hi_fill_d = hi_fill_q + FILL_W'(1);
                status_d  = STATUS_ENQUEUED;
              end
            end
            ACT_ENQ_LOW: begin
              if (lo_fill_q == FILL_MAX) begin
                status_d = STATUS_FULL;
              end else begin
                lo_we     = 1'b1;
                lo_wr_d   = next_ptr(lo_wr_q);
                lo_fill_d = lo_fill_q + FILL_W'(1);
                status_d  = STATUS_ENQUEUED;
              end
            end
            ACT_SERVE: begin
              if (hi_fill_q != '0 && !at_limit) begin
                hi_re       = 1'b1;
                hi_rd_d     = next_ptr(hi_rd_q);
                hi_fill_d   = hi_fill_q - FILL_W'(1);
                burst_d     = burst_q + LIMIT_W'(1);
                sel_high_d  = 1'b1;
                out_valid_d = 1'b0;
                state_d     = FSM_READ;
              end else if (lo_fill_q != '0) begin
                lo_re       = 1'b1;
                lo_rd_d     = next_ptr(lo_rd_q);
                lo_fill_d   = lo_fill_q - FILL_W'(1);
                burst_d     = '0;
                sel_high_d  = 1'b0;
                out_valid_d = 1'b0;
                state_d     = FSM_READ;
              end else if (hi_fill_q != '0) begin
                // run stays at the limit while the low queue is empty
                hi_re       = 1'b1;
                hi_rd_d     = next_ptr(hi_rd_q);
                hi_fill_d   = hi_fill_q - FILL_W'(1);
                sel_high_d  = 1'b1;
                out_valid_d = 1'b0;
                state_d     = FSM_READ;
              end
            end
            default: begin
            end
          endcase
        end
      end
      FSM_READ: begin
        // hold the read tag until the output slot frees up
        if (slot_free) begin
          out_valid_d = 1'b1;
          status_d    = sel_high_q ? STATUS_HIGH : STATUS_LOW;
          svc_d       = rtag[TAG_W-1:REQUESTER_BITS];
          req_d       = rtag[REQUESTER_BITS-1:0];
          state_d     = FSM_IDLE;
        end
      end
      default: begin
        state_d = FSM_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FSM_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hi_rd_q     <= '0;
      hi_wr_q     <= '0;
      lo_rd_q     <= '0;
      lo_wr_q     <= '0;
      hi_fill_q   <= '0;
      lo_fill_q   <= '0;
      burst_q     <= '0;
      limit_q     <= LIMIT_RESET;
      sel_high_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      hi_rd_q     <= hi_rd_d;
      hi_wr_q     <= hi_wr_d;
      lo_rd_q     <= lo_rd_d;
      lo_wr_q     <= lo_wr_d;
      hi_fill_q   <= hi_fill_d;
      lo_fill_q   <= lo_fill_d;
      burst_q     <= burst_d;
      limit_q     <= limit_d;
      sel_high_q  <= sel_high_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    svc_q    <= svc_d;
    req_q    <= req_d;
  end

  tca_ram #(
    .WIDTH (TAG_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_high_ram (
    .clk_i   (clk_i),
    .we_i    (hi_we),
    .waddr_i (hi_wr_q),
    .wdata_i (wtag),
    .re_i    (hi_re),
    .raddr_i (hi_rd_q),
    .rdata_o (hi_rdata)
  );

  tca_ram #(
    .WIDTH (TAG_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_low_ram (
    .clk_i   (clk_i),
    .we_i    (lo_we),
    .waddr_i (lo_wr_q),
    .wdata_i (wtag),
    .re_i    (lo_re),
    .raddr_i (lo_rd_q),
    .rdata_o (lo_rdata)
  );

  assign out_valid_o         = out_valid_q;
  assign status_o            = status_q;
  assign granted_service_o   = svc_q;
  assign granted_requester_o = req_q;

  a_hi_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hi_fill_q <= FILL_MAX)
    else $error("high queue fill count overflow");

  a_lo_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lo_fill_q <= FILL_MAX)
    else $error("low queue fill count overflow");

  a_no_accept_in_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == FSM_READ |-> !in_ready_o)
    else $error("input taken while a grant read is pending");

  a_grant_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == FSM_READ && slot_free) |=>
      (out_valid_q && (status_q == STATUS_HIGH || status_q == STATUS_LOW)))
    else $error("grant read did not reach the output register");

  a_serve_goes_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && action_i == ACT_SERVE && (hi_fill_q != '0 || lo_fill_q != '0)) |=>
      state_q == FSM_READ)
    else $error("serve with a queued tag did not issue a read");

endmodule

[tb/two_class_queue_arbiter_top_test.sv]
`timescale 1ns / 1ps
module two_class_queue_arbiter_top_test;
  import tca_pkg::*;

  localparam int DEPTH = QUEUE_DEPTH_DEF;
  localparam int SVC_W = SERVICE_BITS_DEF;
  localparam int REQ_W = REQUESTER_BITS_DEF;
  localparam int HI    = 0;
  localparam int LO    = 1;
  localparam int PHASE_ITEMS    = 200;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 3000;

  // action code the block does not define
  localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

  typedef enum int {
    QUIET,
    SEND_IDLE,
    RECV_STALL,
    BOTH_IDLE
  } idle_mode_e;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SVC_W-1:0]    svc;
    logic [REQ_W-1:0]    req;
  } grant_t;

  typedef struct packed {
    bit                  is_cfg;
    logic [ACTION_W-1:0] act;
    logic [SVC_W-1:0]    svc;   // limit value on a register row
    logic [REQ_W-1:0]    req;
    int                  reps;
    bit                  typed;
    grant_t              want;
  } dir_row_t;

  typedef struct packed {
    logic [LIMIT_W-1:0] limit;
    idle_mode_e         mode;
    int                 hi_pct;
    int                 lo_pct;
    bit                 hold;
  } phase_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [LIMIT_W-1:0]  cfg_wdata_i;
  logic                in_valid_i;
  logic                in_ready_o;
  logic [ACTION_W-1:0] action_i;
  logic [SVC_W-1:0]    service_id_i;
  logic [REQ_W-1:0]    requester_id_i;
  logic                out_valid_o;
  logic                out_ready_i;
  logic [STATUS_W-1:0] status_o;
  logic [SVC_W-1:0]    granted_service_o;
  logic [REQ_W-1:0]    granted_requester_o;

  two_class_queue_arbiter_top uut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_wdata_i         (cfg_wdata_i),
    .in_valid_i          (in_valid_i),
    .in_ready_o          (in_ready_o),
    .action_i            (action_i),
    .service_id_i        (service_id_i),
    .requester_id_i      (requester_id_i),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .status_o            (status_o),
    .granted_service_o   (granted_service_o),
    .granted_requester_o (granted_requester_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Arbiter state as the block should hold it
  logic [SVC_W-1:0]   tag_svc [2][DEPTH];
  logic [REQ_W-1:0]   tag_req [2][DEPTH];
  int                 rd_ptr [2] = '{0, 0};
  int                 wr_ptr [2] = '{0, 0};
  int                 fill [2]   = '{0, 0};
  logic [LIMIT_W-1:0] run_len     = '0;
  logic [LIMIT_W-1:0] burst_limit = LIMIT_RESET;

  grant_t grant_expect_q[$];
  int     mismatches  = 0;
  int     send_pct    = 0;
  int     stall_pct   = 0;
  bit     hold_req    = 1'b0;
  int     hold_left   = 0;
  int     quiet_count = 0;

  function automatic grant_t pop_tag(int c, logic [STATUS_W-1:0] st);
    grant_t g;
    g = '{st, tag_svc[c][rd_ptr[c]], tag_req[c][rd_ptr[c]]};
    rd_ptr[c] = (rd_ptr[c] + 1) % DEPTH;
    fill[c]--;
    return g;
  endfunction

  function automatic grant_t arbitrate(logic [ACTION_W-1:0] act, logic [SVC_W-1:0] s,
                                       logic [REQ_W-1:0] r);
    grant_t g;
    int     c;
    logic   at_limit;
    g = '{STATUS_NONE, '0, '0};
    case (act)
      ACT_ENQ_HIGH, ACT_ENQ_LOW: begin
        c = (act == ACT_ENQ_HIGH) ? HI : LO;
        if (fill[c] == DEPTH) begin
          g.status = STATUS_FULL;
        end else begin
          tag_svc[c][wr_ptr[c]] = s;
          tag_req[c][wr_ptr[c]] = r;
          wr_ptr[c] = (wr_ptr[c] + 1) % DEPTH;
          fill[c]++;
          g.status = STATUS_ENQUEUED;
        end
      end
      ACT_SERVE: begin
        at_limit = (run_len >= burst_limit);
        if (fill[HI] != 0 && !at_limit) begin
          g = pop_tag(HI, STATUS_HIGH);
          run_len = run_len + LIMIT_W'(1);
        end else if (fill[LO] != 0) begin
          g = pop_tag(LO, STATUS_LOW);
          run_len = '0;
        end else if (fill[HI] != 0) begin
          // starved low queue is empty: keep serving high, hold the run
          g = pop_tag(HI, STATUS_HIGH);
        end
      end
      default: ;
    endcase
    return g;
  endfunction

  task automatic send_word(logic [ACTION_W-1:0] act, logic [SVC_W-1:0] s,
                           logic [REQ_W-1:0] r, bit typed, grant_t want);
    grant_t g;
    while ($urandom_range(0, 99) < send_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    action_i       <= act;
    service_id_i   <= s;
    requester_id_i <= r;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    g = arbitrate(act, s, r);
    grant_expect_q.push_back(typed ? want : g);
  endtask

  task automatic write_limit(logic [LIMIT_W-1:0] v);
    in_valid_i <= 1'b0;
    while (grant_expect_q.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    burst_limit = v;
  endtask

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t: %s expected 0x%0h got 0x%0h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // Result side: check the word taken at this edge, then pick next ready
  always @(posedge clk_i) begin : result_side
    grant_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (grant_expect_q.size() == 0) begin
        $display("%0t: unexpected word status %0d service 0x%0h requester 0x%0h",
                 $time, status_o, granted_service_o, granted_requester_o);
        mismatches++;
      end else begin
        want = grant_expect_q.pop_front();
        check_field("status", int'(want.status), int'(status_o));
        check_field("granted_service", int'(want.svc), int'(granted_service_o));
        check_field("granted_requester", int'(want.req), int'(granted_requester_o));
      end
    end
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req  = 1'b0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_count <= 0;
    end else if (quiet_count >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_count <= quiet_count + 1;
    end
  end

  dir_row_t dir_rows [16] = '{
    '{1'b0, ACT_SERVE,    8'h00, 16'h0000, 1,  1'b1, '{STATUS_NONE, 8'h00, 16'h0000}},
    '{1'b0, ACT_UNUSED,   8'hff, 16'hffff, 1,  1'b1, '{STATUS_NONE, 8'h00, 16'h0000}},
    '{1'b0, ACT_ENQ_HIGH, 8'hff, 16'hffff, 1,  1'b1, '{STATUS_ENQUEUED, 8'h00, 16'h0000}},
    '{1'b0, ACT_SERVE,    8'h00, 16'h0000, 1,  1'b1, '{STATUS_HIGH, 8'hff, 16'hffff}},
    '{1'b0, ACT_ENQ_LOW,  8'h00, 16'h0000, 1,  1'b1, '{STATUS_ENQUEUED, 8'h00, 16'h0000}},
    '{1'b0, ACT_SERVE,    8'h00, 16'h0000, 1,  1'b1, '{STATUS_LOW, 8'h00, 16'h0000}},
    '{1'b0, ACT_ENQ_HIGH, 8'h10, 16'h1000, 16, 1'b0, '0},
    '{1'b0, ACT_ENQ_HIGH, 8'h77, 16'h7777, 1,  1'b1, '{STATUS_FULL, 8'h00, 16'h0000}},
    '{1'b0, ACT_ENQ_LOW,  8'h5a, 16'ha5a5, 1,  1'b0, '0},
    '{1'b1, ACT_SERVE,    8'h01, 16'h0000, 1,  1'b0, '0},
    '{1'b0, ACT_SERVE,    8'h00, 16'h0000, 4,  1'b0, '0},
    '{1'b1, ACT_SERVE,    8'h00, 16'h0000, 1,  1'b0, '0},
    '{1'b0, ACT_ENQ_LOW,  8'hc3, 16'h3c3c, 1,  1'b0, '0},
    '{1'b0, ACT_SERVE,    8'h00, 16'h0000, 2,  1'b0, '0},
    '{1'b1, ACT_SERVE,    8'hff, 16'h0000, 1,  1'b0, '0},
    '{1'b0, ACT_SERVE,    8'h00, 16'h0000, 1,  1'b0, '0}
  };

  phase_t phases [8] = '{
    '{8'd255, QUIET,      40, 20, 1'b0},
    '{8'd1,   SEND_IDLE,  20, 30, 1'b0},
    '{8'd0,   RECV_STALL, 25, 25, 1'b1},
    '{8'd10,  BOTH_IDLE,  30, 30, 1'b0},
    '{8'd3,   QUIET,      15, 15, 1'b0},
    '{8'd2,   SEND_IDLE,  45, 45, 1'b0},
    '{8'd5,   RECV_STALL, 30, 20, 1'b0},
    '{8'd128, BOTH_IDLE,  33, 33, 1'b0}
  };

  initial begin : stimulus
    int                  roll;
    logic [ACTION_W-1:0] act;
    rst_ni         <= 1'b0;
    cfg_we_i       <= 1'b0;
    cfg_wdata_i    <= '0;
    in_valid_i     <= 1'b0;
    action_i       <= ACT_SERVE;
    service_id_i   <= '0;
    requester_id_i <= '0;
    out_ready_i    <= 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) begin
        write_limit(dir_rows[i].svc);
      end else begin
        for (int k = 0; k < dir_rows[i].reps; k++) begin
          send_word(dir_rows[i].act, SVC_W'(dir_rows[i].svc + k),
                    REQ_W'(dir_rows[i].req + k), dir_rows[i].typed, dir_rows[i].want);
        end
      end
    end

    foreach (phases[p]) begin
      write_limit(phases[p].limit);
      send_pct  = (phases[p].mode == SEND_IDLE) ? 69 :
                  (phases[p].mode == BOTH_IDLE) ? 23 : 0;
      stall_pct = (phases[p].mode == RECV_STALL) ? 69 :
                  (phases[p].mode == BOTH_IDLE) ? 23 : 0;
      // long receiver hold-off: the block fills and stalls its input
      if (phases[p].hold) hold_req = 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        roll = $urandom_range(0, 99);
        if (roll < 3) begin
          act = ACT_UNUSED;
        end else if (roll < 3 + phases[p].hi_pct) begin
          act = ACT_ENQ_HIGH;
        end else if (roll < 3 + phases[p].hi_pct + phases[p].lo_pct) begin
          act = ACT_ENQ_LOW;
        end else begin
          act = ACT_SERVE;
        end
        send_word(act, SVC_W'($urandom_range(0, 255)), REQ_W'($urandom_range(0, 65535)),
                  1'b0, '0);
      end
    end

    in_valid_i <= 1'b0;
    while (grant_expect_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
